// ----- src/tlik_pkg.sv -----
`default_nettype none
package tlik_pkg;

	localparam int CordicSteps = 16;
	localparam int AngW = 26;
	localparam int VecW = 48;
	localparam int CfgIdxW = 1;

	localparam logic [CfgIdxW-1:0] REG_UPPER = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_LOWER = 1'b1;

	localparam logic signed [AngW-1:0] DEG90_Q16 = 26'sd5898240;
	localparam logic signed [AngW-1:0] DEG180_Q16 = 26'sd11796480;

	typedef enum logic [3:0] {
		OP_NUM  = 4'b0001,
		OP_DIV  = 4'b0010,
		OP_SQRT = 4'b0100,
		OP_VEC  = 4'b1000
	} dp_op_t;

	typedef struct packed {
		logic  start;
		dp_op_t op;
		logic [1:0] vsel;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_sts_t;

	function automatic logic [AngW-1:0] atan_lut(input logic [4:0] i);
		logic [AngW-1:0] r;
		case (i)
			5'd0: r = 26'd2949120;
			5'd1: r = 26'd1740967;
			5'd2: r = 26'd919879;
			5'd3: r = 26'd466945;
			5'd4: r = 26'd234379;
			5'd5: r = 26'd117305;
			5'd6: r = 26'd58665;
			5'd7: r = 26'd29335;
			5'd8: r = 26'd14668;
			5'd9: r = 26'd7334;
			5'd10: r = 26'd3667;
			5'd11: r = 26'd1833;
			5'd12: r = 26'd917;
			5'd13: r = 26'd458;
			5'd14: r = 26'd229;
			5'd15: r = 26'd115;
			5'd16: r = 26'd57;
			5'd17: r = 26'd29;
			5'd18: r = 26'd14;
			5'd19: r = 26'd7;
			5'd20: r = 26'd4;
			5'd21: r = 26'd2;
			5'd22: r = 26'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/tlik_dp.sv -----
`default_nettype none
module tlik_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tlik_pkg::dp_cmd_t cmd,
	output tlik_pkg::dp_sts_t sts,
	input  wire logic [15:0] l2,
	input  wire logic [15:0] l3,
	input  wire logic signed [15:0] y_in,
	input  wire logic signed [15:0] z_in,
	output logic signed [17:0] shoulder,
	output logic [15:0] elbow
);
	import tlik_pkg::*;

	// shared iterative units: restoring divider, bit-pair sqrt, cordic vectoring
	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_DIV  = 4'b0010,
		U_SQRT = 4'b0100,
		U_VEC  = 4'b1000
	} unit_t;

	unit_t u_q;
	logic [5:0] cnt_q;
	logic signed [33:0] num_q;
	logic [32:0] den_q;
	logic [49:0] rem_q;
	logic [16:0] quo_q;
	logic neg_q;
	logic signed [17:0] c_q;
	logic [16:0] s_q;
	logic [33:0] sv_q, sr_q;
	logic signed [VecW-1:0] vx_q, vy_q;
	logic signed [AngW-1:0] ang_q;
	logic signed [AngW-1:0] el_q, t1_q;
	logic [1:0] vsel_q;

	logic signed [31:0] zsq, ysq;
	logic [31:0] l2sq, l3sq;
	logic signed [33:0] numc;
	logic [33:0] absnum;
	logic [49:0] remsh;
	logic [33:0] sbit, strial;
	logic signed [VecW-1:0] ax, ay, bx, by, mx;
	logic signed [VecW-1:0] ya, bsum;
	logic signed [33:0] l3c;
	logic signed [VecW-1:0] am, bm;
	logic signed [AngW-1:0] sh16, el_fin;
	logic signed [AngW-1:0] shr, elr;

	always_comb begin
		zsq = z_in * z_in;
		ysq = y_in * y_in;
		l2sq = l2 * l2;
		l3sq = l3 * l3;
		numc = 34'(zsq) + 34'(ysq)
			- 34'(signed'({2'b0, l2sq})) - 34'(signed'({2'b0, l3sq}));
		absnum = num_q[33] ? 34'(-num_q) : num_q;
		remsh = {rem_q[48:0], 1'b0};
		sbit = 34'd1 << {cnt_q[4:0], 1'b0};
		strial = sr_q + sbit;
		ya = (y_in < 0) ? VecW'(-32'(y_in)) : VecW'(y_in);
		l3c = 34'(signed'({1'b0, l3})) * 34'(c_q);
		am = VecW'(signed'({1'b0, l3})) * VecW'(signed'({1'b0, s_q}));
		bsum = VecW'(signed'({1'b0, l2, 16'b0})) + VecW'(l3c);
		case (cmd.vsel)
			2'd0: begin ax = VecW'(s_q); ay = VecW'(c_q); end
			2'd1: begin ax = ya; ay = VecW'(z_in); end
			default: begin
				if (bsum < 0) begin ax = -bsum; ay = -am; end
				else begin ax = bsum; ay = am; end
			end
		endcase
		bm = bsum;
		mx = (vy_q < 0) ? -vy_q : vy_q;
		if (vx_q > mx) mx = vx_q;
		bx = vx_q >>> cnt_q[4:0];
		by = vy_q >>> cnt_q[4:0];
		sh16 = DEG90_Q16 - t1_q - ang_q;
		el_fin = el_q;
		shr = (sh16 + 26'sd128) >>> 8;
		elr = (el_fin + 26'sd128) >>> 8;
	end

	logic norm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q <= U_IDLE;
			cnt_q <= '0;
			norm_q <= 1'b0;
		end else begin
			case (u_q)
				U_IDLE: begin
					if (cmd.start) begin
						case (cmd.op)
							OP_NUM: num_q <= numc;
							OP_DIV: begin
								den_q <= {l2, 1'b0} * l3;
								neg_q <= num_q[33];
								rem_q <= '0;
								quo_q <= '0;
								cnt_q <= '0;
								u_q <= U_DIV;
							end
							OP_SQRT: begin
								sv_q <= 34'(33'h100000000 - 34'(c_q * c_q));
								sr_q <= '0;
								cnt_q <= 6'd16;
								u_q <= U_SQRT;
							end
							OP_VEC: begin
								vsel_q <= cmd.vsel;
								vx_q <= ax;
								vy_q <= ay;
								ang_q <= '0;
								cnt_q <= '0;
								norm_q <= 1'b1;
								u_q <= U_VEC;
							end
							default: ;
						endcase
					end
				end
				U_DIV: begin
					// quotient of |num|*2^16 / den, 17 bits, saturated at 1.0
					if (absnum >= 34'(den_q)) begin
						c_q <= neg_q ? -18'sd65536 : 18'sd65536;
						u_q <= U_IDLE;
					end else begin
						if (cnt_q == 6'd0) rem_q <= {16'b0, absnum};
						else begin
							if (remsh >= 50'(den_q)) begin
								rem_q <= remsh - 50'(den_q);
								quo_q <= {quo_q[15:0], 1'b1};
							end else begin
								rem_q <= remsh;
								quo_q <= {quo_q[15:0], 1'b0};
							end
						end
						if (cnt_q == 6'd16) begin
							// final result taken next cycle via extra step
							cnt_q <= 6'd17;
						end else if (cnt_q == 6'd17) begin
							c_q <= neg_q ? -18'(quo_q) : 18'(quo_q);
							u_q <= U_IDLE;
						end else cnt_q <= cnt_q + 6'd1;
					end
				end
				U_SQRT: begin
					if (sv_q >= strial) begin
						sv_q <= sv_q - strial;
						sr_q <= (sr_q >> 1) + sbit;
					end else sr_q <= sr_q >> 1;
					if (cnt_q == 6'd0) begin
						u_q <= U_IDLE;
						cnt_q <= '0;
					end else cnt_q <= cnt_q - 6'd1;
				end
				U_VEC: begin
					if (norm_q) begin
						if (mx < (VecW'(1) <<< 40)) begin
							vx_q <= vx_q <<< 1;
							vy_q <= vy_q <<< 1;
						end else norm_q <= 1'b0;
					end else begin
						if (vy_q >= 0) begin
							vx_q <= vx_q + by;
							vy_q <= vy_q - bx;
							ang_q <= ang_q + AngW'(signed'(atan_lut(cnt_q[4:0])));
						end else begin
							vx_q <= vx_q - by;
							vy_q <= vy_q + bx;
							ang_q <= ang_q - AngW'(signed'(atan_lut(cnt_q[4:0])));
						end
						if (cnt_q == 6'(CordicSteps - 1)) begin
							u_q <= U_IDLE;
							case (vsel_q)
								2'd0: el_q <= DEG90_Q16 - (ang_q + ((vy_q >= 0)
									? AngW'(signed'(atan_lut(cnt_q[4:0])))
									: -AngW'(signed'(atan_lut(cnt_q[4:0])))));
								2'd1: t1_q <= ang_q + ((vy_q >= 0)
									? AngW'(signed'(atan_lut(cnt_q[4:0])))
									: -AngW'(signed'(atan_lut(cnt_q[4:0]))));
								default: ;
							endcase
						end else cnt_q <= cnt_q + 6'd1;
					end
				end
				default: u_q <= U_IDLE;
			endcase
			// sqrt result latched when sqrt finishes
			if (u_q == U_SQRT && cnt_q == 6'd0) begin
				s_q <= (sv_q >= strial) ? 17'((sr_q >> 1) + sbit) : 17'(sr_q >> 1);
			end
			// straight arm or fully folded: exact angle, no cordic pass
			if (cmd.start && u_q == U_IDLE && cmd.op == OP_VEC && cmd.vsel == 2'd0
				&& s_q == 17'd0) begin
				el_q <= (c_q > 0) ? '0 : DEG180_Q16;
				u_q <= U_IDLE;
			end
			if (cmd.start && u_q == U_IDLE && cmd.op == OP_VEC && cmd.vsel == 2'd2
				&& bm == 0) begin
				ang_q <= DEG90_Q16;
				u_q <= U_IDLE;
			end
		end
	end

	assign sts.busy = (u_q != U_IDLE);

	always_comb begin
		if (shr < -26'sd5120) shoulder = -18'sd5120;
		else if (shr > 26'sd69120) shoulder = 18'sd69120;
		else shoulder = 18'(shr);
		if (elr < 0) elbow = '0;
		else if (elr > 26'sd46080) elbow = 16'd46080;
		else elbow = 16'(elr);
	end

endmodule
`default_nettype wire

// ----- src/tlik_ctrl.sv -----
`default_nettype none
module tlik_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  wire logic [16:0] s_val,
	input  wire tlik_pkg::dp_sts_t sts,
	output tlik_pkg::dp_cmd_t cmd,
	output logic done
);
	import tlik_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_NUM  = 8'b00000010,
		S_DIV  = 8'b00000100,
		S_SQRT = 8'b00001000,
		S_EL   = 8'b00010000,
		S_T1   = 8'b00100000,
		S_T2   = 8'b01000000,
		S_DONE = 8'b10000000
	} state_t;

	state_t st_q;
	logic issued_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			issued_q <= 1'b0;
		end else begin
			if (cmd.start) issued_q <= 1'b1;
			case (st_q)
				S_IDLE: if (go) st_q <= S_NUM;
				S_NUM: begin st_q <= S_DIV; issued_q <= 1'b0; end
				S_DIV: if (issued_q && !sts.busy) begin st_q <= S_SQRT; issued_q <= 1'b0; end
				S_SQRT: if (issued_q && !sts.busy) begin st_q <= S_EL; issued_q <= 1'b0; end
				S_EL: if ((issued_q && !sts.busy) || (s_val == '0 && issued_q)) begin
					st_q <= S_T1; issued_q <= 1'b0;
				end
				S_T1: if (issued_q && !sts.busy) begin st_q <= S_T2; issued_q <= 1'b0; end
				S_T2: if (issued_q && !sts.busy) begin st_q <= S_DONE; issued_q <= 1'b0; end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.start = 1'b0;
		cmd.op = OP_NUM;
		cmd.vsel = 2'd0;
		case (st_q)
			S_NUM: cmd.start = 1'b1;
			S_DIV: begin cmd.start = !issued_q; cmd.op = OP_DIV; end
			S_SQRT: begin cmd.start = !issued_q; cmd.op = OP_SQRT; end
			S_EL: begin cmd.start = !issued_q; cmd.op = OP_VEC; end
			S_T1: begin cmd.start = !issued_q; cmd.op = OP_VEC; cmd.vsel = 2'd1; end
			S_T2: begin cmd.start = !issued_q; cmd.op = OP_VEC; cmd.vsel = 2'd2; end
			default: ;
		endcase
		done = (st_q == S_DONE);
	end

endmodule
`default_nettype wire

// ----- src/two_link_arm_inverse_kinematics.sv -----
`default_nettype none
// Inverse kinematics for a base plus two-link arm in Q8 fixed point. One item is in
// the block at a time and the input stalls until its result transfers. For a target
// with nonzero reach, one shared unit runs a divide (cut short when the ratio saturates),
// a 17-step square root and three CORDIC vectoring passes, each a run of normalize
// shifts plus 16 steps, with a command handoff before and after each unit. A fully
// stretched or folded arm or a zero second denominator skips its CORDIC pass. A target
// with zero reach skips the computation and returns the held angles with updated low.
// Link lengths are to be written through the cfg port only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
module two_link_arm_inverse_kinematics (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [tlik_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [47:0] s_tdata, // base_request, reach_y, height_z
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [55:0] m_tdata, // base_angle, shoulder_angle, elbow_angle, pad
	output logic m_tuser // updated
);
	import tlik_pkg::*;

	logic [15:0] l2_q, l3_q;
	logic signed [15:0] y_q, z_q, base_q;
	logic signed [15:0] hb_q;
	logic signed [17:0] hs_q;
	logic [15:0] he_q;
	logic busy_q, upd_q, go, done;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic signed [17:0] sh;
	logic [15:0] el;
	logic signed [15:0] breq, bcl;

	assign cfg_ready = 1'b1;
	assign s_tready = !busy_q && !m_tvalid;
	assign breq = s_tdata[15:0];
	assign bcl = (breq > 16'sd23040) ? 16'sd23040 : (breq < -16'sd23040) ? -16'sd23040 : breq;
	assign go = s_tvalid && s_tready && (s_tdata[31:16] != '0);

	tlik_ctrl u_ctrl (.clk, .arst_n, .go, .s_val(17'd1), .sts, .cmd, .done);
	tlik_dp u_dp (.clk, .arst_n, .cmd, .sts, .l2(l2_q), .l3(l3_q), .y_in(y_q),
		.z_in(z_q), .shoulder(sh), .elbow(el));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l2_q <= 16'd2560;
			l3_q <= 16'd2560;
			hb_q <= '0;
			hs_q <= '0;
			he_q <= '0;
			busy_q <= 1'b0;
			m_tvalid <= 1'b0;
			upd_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_UPPER) l2_q <= cfg_data;
			if (cfg_valid && cfg_index == REG_LOWER) l3_q <= cfg_data;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (s_tvalid && s_tready) begin
				y_q <= s_tdata[31:16];
				z_q <= s_tdata[47:32];
				base_q <= bcl;
				if (go) busy_q <= 1'b1;
				else begin
					m_tvalid <= 1'b1;
					upd_q <= 1'b0;
				end
			end
			if (done) begin
				busy_q <= 1'b0;
				hb_q <= base_q;
				hs_q <= sh;
				he_q <= el;
				upd_q <= 1'b1;
				m_tvalid <= 1'b1;
			end
		end
	end

	assign m_tdata = {6'b0, he_q, hs_q, hb_q};
	assign m_tuser = upd_q;

endmodule
`default_nettype wire
